FILE: design/irpd_pkg.sv
// Shared types and constants for the infrared pulse-distance frame encoder.
// No dependencies; used by irpd_cfg_regs, ir_pulse_distance_frame_encoder and tb_top.
package irpd_pkg;

  localparam int unsigned FrameBytes = 13;
  localparam int unsigned PosW       = (FrameBytes > 1) ? $clog2(FrameBytes) : 1;
  localparam int unsigned DurW       = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned StepW      = 5;

  // Sequence steps: three header durations, then sixteen per byte.
  localparam logic [StepW-1:0] StepStart = 5'd0;
  localparam logic [StepW-1:0] StepHdrSp = 5'd1;
  localparam logic [StepW-1:0] StepHdrPs = 5'd2;
  localparam logic [StepW-1:0] StepData  = 5'd3;
  localparam logic [StepW-1:0] StepFinal = 5'd18;

  localparam logic [DurW-1:0] StartRst  = 16'd3750;
  localparam logic [DurW-1:0] HdrSpRst  = 16'd1950;
  localparam logic [DurW-1:0] PauseRst  = 16'd400;
  localparam logic [DurW-1:0] ZeroRst   = 16'd550;
  localparam logic [DurW-1:0] OneRst    = 16'd1450;

  typedef enum logic [CfgIdxW-1:0] {
    RegStart = 3'd0,
    RegHdrSp = 3'd1,
    RegPause = 3'd2,
    RegZero  = 3'd3,
    RegOne   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DurW-1:0] start;
    logic [DurW-1:0] hdr_space;
    logic [DurW-1:0] pause;
    logic [DurW-1:0] zero;
    logic [DurW-1:0] one;
  } cfg_t;

endpackage

FILE: design/irpd_cfg_regs.sv
// Timing register file of the infrared pulse-distance frame encoder.
// Depends on irpd_pkg for the register indexes and the cfg_t bundle.
module irpd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [irpd_pkg::CfgIdxW-1:0] wr_idx_i,
  input  logic [irpd_pkg::DurW-1:0]    wr_data_i,
  output irpd_pkg::cfg_t               cfg_o
);
  import irpd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        RegStart: cfg_d.start     = wr_data_i;
        RegHdrSp: cfg_d.hdr_space = wr_data_i;
        RegPause: cfg_d.pause     = wr_data_i;
        RegZero:  cfg_d.zero      = wr_data_i;
        RegOne:   cfg_d.one       = wr_data_i;
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start     <= StartRst;
      cfg_q.hdr_space <= HdrSpRst;
      cfg_q.pause     <= PauseRst;
      cfg_q.zero      <= ZeroRst;
      cfg_q.one       <= OneRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/ir_pulse_distance_frame_encoder.sv
// Top level of the infrared pulse-distance frame encoder.
// Depends on irpd_pkg and irpd_cfg_regs.
//
// Frame bytes enter on the s_axis channel, byte 0 of a frame first, a fixed
// number of bytes per frame. Each byte becomes a run of mark/space words on the
// m_axis channel: sixteen words, nineteen for the first byte of a frame, which
// also carries the header. tlast marks the last word of a byte's run and
// tuser[1] the last word of the frame. In the last byte the upper nibble is
// replaced by the parity nibble of the whole frame.
// A byte is registered on acceptance; its words then leave through the single
// output register, one word per cycle while the receiver does not stall.
// The next byte is taken in the cycle the last word of the current run is
// issued, so runs follow without a gap.
// When the receiver stalls, the output word holds and the sequence pauses.
// Reset empties the output, clears the frame position and parity and loads
// the default timings. The cfg port is always ready; the user writes it only while
// the encoder is idle (not enforced); writes to an index above four are ignored.
module ir_pulse_distance_frame_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // frame_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [irpd_pkg::DurW-1:0]    m_axis_tdata,   // duration_us
  output logic                         m_axis_tlast,   // run_end
  output logic [1:0]                   m_axis_tuser,   // is_mark, frame_end
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [irpd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [irpd_pkg::DurW-1:0]    cfg_data_i
);
  import irpd_pkg::*;

  cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  irpd_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (cfg_valid_i),
    .wr_idx_i (cfg_index_i),
    .wr_data_i(cfg_data_i),
    .cfg_o    (cfg)
  );

  logic            busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]      par_q, par_d;

  logic            ov_q, ov_d;
  logic [DurW-1:0] dur_q, dur_d;
  logic            mark_q, mark_d;
  logic            rend_q, rend_d;
  logic            fend_q, fend_d;

  logic            out_adv, issue, in_acc, is_last_in;
  logic [7:0]      in_byte;
  logic [StepW-1:0] didx;
  logic [2:0]      bit_sel;

  assign out_adv       = !ov_q || m_axis_tready;
  assign issue         = busy_q && out_adv;
  assign s_axis_tready = !busy_q || (issue && (step_q == StepFinal));
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign is_last_in = (pos_q >= PosW'(FrameBytes - 1));
  assign in_byte    = is_last_in ? {par_q ^ s_axis_tdata[3:0], s_axis_tdata[3:0]}
                                 : s_axis_tdata;

  assign didx    = step_q - StepData;
  assign bit_sel = didx[3:1];

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    byte_d = byte_q;
    last_d = last_q;
    pos_d  = pos_q;
    par_d  = par_q;
    ov_d   = ov_q;
    dur_d  = dur_q;
    mark_d = mark_q;
    rend_d = rend_q;
    fend_d = fend_q;

    if (out_adv) begin
      ov_d = issue;
    end

    if (issue) begin
      step_d = step_q + 5'd1;
      if (step_q == StepFinal) begin
        busy_d = 1'b0;
      end
      case (step_q)
        StepStart: begin
          dur_d  = cfg.start;
          mark_d = 1'b1;
        end
        StepHdrSp: begin
          dur_d  = cfg.hdr_space;
          mark_d = 1'b0;
        end
        StepHdrPs: begin
          dur_d  = cfg.pause;
          mark_d = 1'b1;
        end
        default: begin
          mark_d = didx[0];
          if (didx[0]) begin
            dur_d = cfg.pause;
          end else begin
            dur_d = byte_q[bit_sel] ? cfg.one : cfg.zero;
          end
        end
      endcase
      rend_d = (step_q == StepFinal);
      fend_d = (step_q == StepFinal) && last_q;
    end

    if (in_acc) begin
      busy_d = 1'b1;
      step_d = (pos_q == '0) ? StepStart : StepData;
      byte_d = in_byte;
      last_d = is_last_in;
      if (is_last_in) begin
        pos_d = '0;
        par_d = 4'h0;
      end else begin
        pos_d = pos_q + PosW'(1);
        par_d = par_q ^ in_byte[3:0] ^ in_byte[7:4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= StepStart;
      last_q <= 1'b0;
      pos_q  <= '0;
      par_q  <= 4'h0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      last_q <= last_d;
      pos_q  <= pos_d;
      par_q  <= par_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    dur_q  <= dur_d;
    mark_q <= mark_d;
    rend_q <= rend_d;
    fend_q <= fend_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = dur_q;
  assign m_axis_tlast  = rend_q;
  assign m_axis_tuser  = {fend_q, mark_q};

  a_frame_end_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("frame end word without run end");

  a_step_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= StepFinal)
    else $error("step counter beyond final step");

  a_accept_starts_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && (step_q == StepStart || step_q == StepData))
    else $error("accepted byte did not start a run");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(FrameBytes - 1))
    else $error("frame position out of range");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for ir_pulse_distance_frame_encoder.
// Depends on irpd_pkg and the encoder RTL. Frame bytes go in with random bursts and
// gaps, and each output word is checked against a local model of the encoder.
module tb_top;
  import irpd_pkg::*;

  localparam int unsigned UserMarkBit     = 0;
  localparam int unsigned UserFrameEndBit = 1;
  localparam logic [CfgIdxW-1:0] FirstUnusedIdx = 3'd5;

  typedef struct packed {
    logic [DurW-1:0] dur;
    logic            is_mark;
    logic            run_end;
    logic            frame_end;
  } dur_word_t;

  typedef enum int unsigned {
    ReadyAlways,
    ReadyRandom,
    ReadyEveryThird,
    ReadyLongStall
  } ready_mode_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DurW-1:0]   m_axis_tdata;
  logic              m_axis_tlast;
  logic [1:0]        m_axis_tuser;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i  = '0;
  logic [DurW-1:0]   cfg_data_i    = '0;

  cfg_t        timing = '{StartRst, HdrSpRst, PauseRst, ZeroRst, OneRst};
  logic [4:0]  frame_pos  = '0;
  logic [3:0]  parity_nib = '0;
  dur_word_t   expected_words[$];
  int unsigned error_count = 0;
  int unsigned burst_left  = 0;

  ir_pulse_distance_frame_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void push_word(logic [DurW-1:0] d, logic mark, logic run_end,
                                    logic frame_end);
    dur_word_t w;
    w = '{dur: d, is_mark: mark, run_end: run_end, frame_end: frame_end};
    expected_words.push_back(w);
  endfunction

  function automatic void encode_frame_byte(logic [7:0] b);
    logic       last;
    logic [7:0] sent;
    last = (frame_pos >= FrameBytes - 1);
    sent = b;
    if (frame_pos == 0) begin
      push_word(timing.start, 1'b1, 1'b0, 1'b0);
      push_word(timing.hdr_space, 1'b0, 1'b0, 1'b0);
      push_word(timing.pause, 1'b1, 1'b0, 1'b0);
    end
    // The closing byte carries the parity of every nibble in the frame.
    if (last) sent[7:4] = parity_nib ^ b[3:0];
    for (int i = 0; i < 8; i++) begin
      push_word(sent[i] ? timing.one : timing.zero, 1'b0, 1'b0, 1'b0);
      push_word(timing.pause, 1'b1, i == 7, (i == 7) && last);
    end
    if (last) begin
      frame_pos  = '0;
      parity_nib = '0;
    end else begin
      parity_nib = parity_nib ^ sent[3:0] ^ sent[7:4];
      frame_pos  = frame_pos + 5'd1;
    end
  endfunction

  function automatic void apply_timing_write(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] val);
    case (idx)
      RegStart: timing.start     = val;
      RegHdrSp: timing.hdr_space = val;
      RegPause: timing.pause     = val;
      RegZero:  timing.zero      = val;
      RegOne:   timing.one       = val;
      default: ;
    endcase
  endfunction

  task automatic note_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // Output words are checked first, then accepted bytes and register writes update
  // the model, all in one process so that the order within an edge is fixed.
  always @(posedge clk_i) begin
    dur_word_t exp_w;
    dur_word_t got_w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_w = '{dur: m_axis_tdata, is_mark: m_axis_tuser[UserMarkBit],
                  run_end: m_axis_tlast, frame_end: m_axis_tuser[UserFrameEndBit]};
        if (expected_words.size() == 0) begin
          note_failure($sformatf("Unexpected word: dur=%0d mark=%0b run_end=%0b frame_end=%0b",
                                 got_w.dur, got_w.is_mark, got_w.run_end, got_w.frame_end));
        end else begin
          exp_w = expected_words.pop_front();
          if (got_w !== exp_w) begin
            note_failure($sformatf({"Mismatch: expected dur=%0d mark=%0b run_end=%0b ",
                                    "frame_end=%0b, got dur=%0d mark=%0b run_end=%0b frame_end=%0b"},
                                   exp_w.dur, exp_w.is_mark, exp_w.run_end, exp_w.frame_end,
                                   got_w.dur, got_w.is_mark, got_w.run_end, got_w.frame_end));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) encode_frame_byte(s_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) apply_timing_write(cfg_index_i, cfg_data_i);
    end
  end

  ready_mode_e ready_mode  = ReadyAlways;
  int unsigned mode_cycles = 0;
  int unsigned ready_tick  = 0;

  always @(posedge clk_i) begin
    if (mode_cycles == 0) begin
      ready_mode  = ready_mode_e'($urandom_range(0, 3));
      mode_cycles = $urandom_range(20, 200);
    end
    mode_cycles--;
    ready_tick++;
    case (ready_mode)
      ReadyAlways:     m_axis_tready <= 1'b1;
      ReadyRandom:     m_axis_tready <= 1'($urandom_range(0, 1));
      ReadyEveryThird: m_axis_tready <= (ready_tick % 3 == 0);
      default:         m_axis_tready <= (ready_tick % 32 < 4);
    endcase
  end

  task automatic send_byte(logic [7:0] b);
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24)) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [DurW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Also writes one index beyond the register map, which must change nothing.
  task automatic program_timing(cfg_t t);
    cfg_write(RegStart, t.start);
    cfg_write(RegHdrSp, t.hdr_space);
    cfg_write(RegPause, t.pause);
    cfg_write(RegZero, t.zero);
    cfg_write(RegOne, t.one);
    cfg_write(FirstUnusedIdx + CfgIdxW'($urandom_range(0, 2)), 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_default_frame();
    logic [7:0] frame[13] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h0F,
                              8'hF0, 8'h3C, 8'hC3, 8'h7E, 8'h81, 8'hFF};
    foreach (frame[i]) send_byte(frame[i]);
    drain_outputs();
  endtask

  task automatic test_extreme_timing();
    program_timing('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h96);
    drain_outputs();
  endtask

  // The timing is changed while a frame is still open, and the frame is then completed.
  task automatic test_midframe_reprogram();
    program_timing('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
    for (int i = 0; i < 10; i++) send_byte(8'($urandom));
    drain_outputs();
  endtask

  task automatic test_random_traffic();
    cfg_t t;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        t = '{StartRst, HdrSpRst, PauseRst, ZeroRst, OneRst};
      end else begin
        t = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        if ($urandom_range(0, 3) == 0) t.start = '0;
        if ($urandom_range(0, 3) == 0) t.pause = '1;
        if ($urandom_range(0, 3) == 0) t.zero  = '0;
        if ($urandom_range(0, 3) == 0) t.one   = '1;
      end
      program_timing(t);
      for (int i = 0; i < 65; i++) send_byte(8'($urandom_range(0, 255)));
      drain_outputs();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_frame();
    test_extreme_timing();
    test_midframe_reprogram();
    test_random_traffic();
    repeat (25) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
design/irpd_pkg.sv
design/irpd_cfg_regs.sv
design/ir_pulse_distance_frame_encoder.sv
sim/tb_top.sv
